/* rtl/core/lzss_decompressor_macros.svh */
// ----------------------------------------------------------------------------
// lzss_decompressor_macros.svh
// Assertion macros used by the decompressor port checker.
// The module that uses them must have signals named clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef LZSS_DECOMPRESSOR_MACROS_SVH
`define LZSS_DECOMPRESSOR_MACROS_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define LZD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Same, but also checked across reset (for reset behavior itself).
`define LZD_ASSERT_NEXT_ANY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/lzd_pkg.sv */
// ----------------------------------------------------------------------------
// lzd_pkg
// Types and constants shared by the LZSS decompressor modules.
// ----------------------------------------------------------------------------
package lzd_pkg;

  localparam int WINDOW_DEPTH_DEF = 4096;
  localparam int POS_W            = 12;
  localparam int LEN_W            = 4;
  localparam int CODE_W           = 16;
  localparam int CNT_W            = 5;
  localparam int LIMIT_W          = 32;
  localparam int QUEUE_DEPTH      = 2;
  localparam int QP_W             = $clog2(QUEUE_DEPTH);
  localparam int QC_W             = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]         FILL_BYTE    = 8'h20;
  localparam logic [CNT_W-1:0]   MIN_MATCH_M1 = CNT_W'(1);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = '1;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_TOKEN,
    PH_LOW
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_LIT,
    CMD_MATCH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CODE_W-1:0] code;
    logic              last;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_WRAP,
    BK_READ,
    BK_DATA,
    BK_LIT
  } back_state_t;

endpackage

/* rtl/core/lzd_ram.sv */
// ----------------------------------------------------------------------------
// lzd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/lzd_front.sv */
// ----------------------------------------------------------------------------
// lzd_front
// Token parser: tracks flag bits and turns each input byte into a command.
// ----------------------------------------------------------------------------
module lzd_front import lzd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       q_full,
  output logic       push,
  output cmd_t       push_cmd
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] flags_r, flags_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [7:0] high_r, high_nxt;
  logic       accept;
  logic       bit_set;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept;
  assign bit_set  = flags_r[idx_r];

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_TOKEN: begin
        if (bit_set) begin
          phase_nxt = PH_LOW;
        end else begin
          phase_nxt = (idx_r == 3'd7) ? PH_FLAG : PH_TOKEN;
        end
      end
      PH_LOW: begin
        phase_nxt = (idx_r == 3'd7) ? PH_FLAG : PH_TOKEN;
      end
      default: begin
        phase_nxt = PH_TOKEN;
      end
    endcase
    if (in_last) begin
      phase_nxt = PH_FLAG;
    end
  end

  // Command and token bookkeeping
  always_comb begin
    flags_nxt     = flags_r;
    idx_nxt       = idx_r;
    high_nxt      = high_r;
    push_cmd.kind = CMD_NONE;
    push_cmd.code = {8'h00, in_byte};
    push_cmd.last = in_last;
    case (phase_r)
      PH_TOKEN: begin
        if (bit_set) begin
          high_nxt = in_byte;
        end else begin
          push_cmd.kind = CMD_LIT;
          idx_nxt       = idx_r + 3'd1;
        end
      end
      PH_LOW: begin
        push_cmd.kind = CMD_MATCH;
        push_cmd.code = {high_r, in_byte};
        idx_nxt       = idx_r + 3'd1;
      end
      default: begin
        flags_nxt = in_byte;
        idx_nxt   = 3'd0;
      end
    endcase
    // end of stream: start the next one clean
    if (in_last) begin
      flags_nxt = 8'h00;
      idx_nxt   = 3'd0;
      high_nxt  = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FLAG;
      flags_r <= 8'h00;
      idx_r   <= 3'd0;
      high_r  <= 8'h00;
    end else if (accept) begin
      phase_r <= phase_nxt;
      flags_r <= flags_nxt;
      idx_r   <= idx_nxt;
      high_r  <= high_nxt;
    end
  end

endmodule

/* rtl/core/lzd_queue.sv */
// ----------------------------------------------------------------------------
// lzd_queue
// Short command FIFO between the parser and the copy engine.
// ----------------------------------------------------------------------------
module lzd_queue import lzd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam logic [QP_W-1:0] LAST_SLOT = QP_W'(QUEUE_DEPTH - 1);
  localparam logic [QC_W-1:0] FULL_CNT  = QC_W'(QUEUE_DEPTH);

  cmd_t            mem_r [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + QP_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + QP_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QC_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* rtl/core/lzd_back.sv */
// ----------------------------------------------------------------------------
// lzd_back
// Copy engine: emits literals and window copies, keeps the history window,
// the output count and the output register.
// ----------------------------------------------------------------------------
module lzd_back import lzd_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  cmd_t               head_cmd,
  output logic               pop,
  input  logic [LIMIT_W-1:0] limit,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_run_last
);

  localparam int              AW        = $clog2(WINDOW_DEPTH);
  localparam logic [POS_W:0]  DEPTH_W   = (POS_W + 1)'(WINDOW_DEPTH);
  localparam logic [POS_W-1:0] DEPTH_P  = POS_W'(WINDOW_DEPTH);
  localparam logic [AW-1:0]   LAST_ADDR = AW'(WINDOW_DEPTH - 1);

  back_state_t        state_r, state_nxt;
  logic [POS_W-1:0]   addr_r, addr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               last_r, last_nxt;
  logic [7:0]         lit_r, lit_nxt;
  logic               hit_r, hit_nxt;
  logic [AW-1:0]      wp_r, wp_nxt;
  logic               wrapped_r, wrapped_nxt;
  logic [LIMIT_W-1:0] produced_r, produced_nxt;
  logic               stopped_r, stopped_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  logic               out_last_r, out_last_nxt;

  logic               out_free;
  logic               head_stop;
  logic [LIMIT_W-1:0] prod_inc;
  logic               reach;
  logic [AW-1:0]      addr_idx;
  logic [AW-1:0]      addr_idx_inc;
  logic               emit;
  logic [7:0]         emit_byte;
  logic               emit_last;
  logic               finish;
  logic               ram_re;
  logic [7:0]         ram_rdata;

  assign out_free     = !out_valid_r || !out_stall;
  assign head_stop    = stopped_r || (produced_r >= limit);
  assign prod_inc     = produced_r + LIMIT_W'(1);
  assign reach        = (prod_inc >= limit);
  assign addr_idx     = addr_r[AW-1:0];
  assign addr_idx_inc = (addr_idx == LAST_ADDR) ? '0 : addr_idx + AW'(1);

  lzd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (emit),
    .waddr (wp_r),
    .wdata (emit_byte),
    .re    (ram_re),
    .raddr (addr_idx),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (head_valid && !head_stop) begin
          case (head_cmd.kind)
            CMD_LIT:   state_nxt = BK_LIT;
            CMD_MATCH: state_nxt = BK_WRAP;
            default:   state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_WRAP: begin
        if ({1'b0, addr_r} < DEPTH_W) begin
          state_nxt = BK_READ;
        end
      end
      BK_READ: begin
        state_nxt = BK_DATA;
      end
      BK_DATA: begin
        if (out_free) begin
          state_nxt = ((cnt_r == '0) || reach) ? BK_IDLE : BK_READ;
        end
      end
      BK_LIT: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Datapath and outputs
  always_comb begin
    addr_nxt      = addr_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    lit_nxt       = lit_r;
    hit_nxt       = hit_r;
    wp_nxt        = wp_r;
    wrapped_nxt   = wrapped_r;
    produced_nxt  = produced_r;
    stopped_nxt   = stopped_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;
    ram_re        = 1'b0;
    emit          = 1'b0;
    emit_byte     = lit_r;
    emit_last     = 1'b1;
    finish        = 1'b0;

    case (state_r)
      BK_IDLE: begin
        if (head_valid) begin
          pop      = 1'b1;
          last_nxt = head_cmd.last;
          lit_nxt  = head_cmd.code[7:0];
          addr_nxt = head_cmd.code[CODE_W-1:LEN_W];
          cnt_nxt  = CNT_W'(head_cmd.code[LEN_W-1:0]) + MIN_MATCH_M1;
          if (head_stop) begin
            stopped_nxt = 1'b1;
            finish      = head_cmd.last;
          end else if (head_cmd.kind != CMD_LIT && head_cmd.kind != CMD_MATCH) begin
            finish = head_cmd.last;
          end
        end
      end
      BK_WRAP: begin
        // bring the match position into the window
        if ({1'b0, addr_r} >= DEPTH_W) begin
          addr_nxt = addr_r - DEPTH_P;
        end
      end
      BK_READ: begin
        ram_re  = 1'b1;
        // entries not yet written in this stream read as fill bytes
        hit_nxt = wrapped_r || (addr_idx < wp_r);
      end
      BK_DATA: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = hit_r ? ram_rdata : FILL_BYTE;
          emit_last = (cnt_r == '0) || reach;
          cnt_nxt   = cnt_r - CNT_W'(1);
          addr_nxt  = POS_W'(addr_idx_inc);
          finish    = emit_last && last_r;
        end
      end
      BK_LIT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = lit_r;
          emit_last = 1'b1;
          finish    = last_r;
        end
      end
      default: begin
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_byte;
      out_last_nxt  = emit_last;
      wp_nxt        = (wp_r == LAST_ADDR) ? '0 : wp_r + AW'(1);
      wrapped_nxt   = wrapped_r || (wp_r == LAST_ADDR);
      produced_nxt  = prod_inc;
      if (reach) begin
        stopped_nxt = 1'b1;
      end
    end

    // stream end: window, count and stop flag start over
    if (finish) begin
      wp_nxt       = '0;
      wrapped_nxt  = 1'b0;
      produced_nxt = '0;
      stopped_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      produced_r  <= '0;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      wrapped_r   <= wrapped_nxt;
      produced_r  <= produced_nxt;
      stopped_r   <= stopped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    cnt_r      <= cnt_nxt;
    last_r     <= last_nxt;
    lit_r      <= lit_nxt;
    hit_r      <= hit_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_last = out_last_r;

endmodule

/* rtl/core/lzss_decompressor.sv */
// ----------------------------------------------------------------------------
// lzss_decompressor
// LZSS stream decompressor, 12-bit window position and 4-bit length.
// ----------------------------------------------------------------------------
// A parser takes one compressed byte per cycle, while the two-entry command
// queue is not full, into that queue; a copy engine behind it drains the
// queue. Flag bytes and match high bytes are popped as empty commands, a
// literal is output directly, and a match of length 2..17 folds its position
// into the window (subtracting the window depth while it lies beyond) and
// reads each copied byte from the window RAM before its write and output.
// The window needs no clearing pass: a write count per stream marks which
// entries hold data, and the others read as 0x20, so a new stream starts at
// once after in_last.
// output_limit should be written only while the block is idle.
// ----------------------------------------------------------------------------
module lzss_decompressor import lzd_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_run_last,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data
);

  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic               push;
  cmd_t               push_cmd;
  logic               q_full;
  logic               pop;
  logic               head_valid;
  cmd_t               head_cmd;

  assign limit_nxt = cfg_wr_en ? cfg_wr_data : limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  lzd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  lzd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  lzd_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head_cmd     (head_cmd),
    .pop          (pop),
    .limit        (limit_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

endmodule

/* rtl/core/lzd_checker.sv */
// ----------------------------------------------------------------------------
// lzd_checker
// Port-level checks for the decompressor, bound to the top level.
// ----------------------------------------------------------------------------
`include "lzss_decompressor_macros.svh"

module lzd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_run_last
);

  logic [8:0] out_word;

  assign out_word = {out_byte, out_run_last};

  // Hold a stalled output transaction
  `LZD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled output dropped")
  `LZD_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_word), "payload changed")

  // Reset empties the output register and the command queue
  `LZD_ASSERT_NEXT_ANY(a_rst_out, !rst_n, !out_valid, "output valid after reset")
  `LZD_ASSERT_NEXT_ANY(a_rst_in, !rst_n, !in_stall, "input stalled after reset")

endmodule

bind lzss_decompressor lzd_checker u_lzd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_byte     (out_byte),
  .out_run_last (out_run_last)
);

/* sim/lzss_decompressor_checker.sv */
// ----------------------------------------------------------------------------
// lzss_decompressor_checker
// Watches the input, result and configuration ports of the decompressor,
// decodes each accepted input byte into the bytes it must produce, and
// compares every result transaction in order against them.
// ----------------------------------------------------------------------------
module lzss_decompressor_checker import lzd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [7:0]         out_byte,
  input  logic               out_run_last,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
  } out_beat_t;

  out_beat_t expected_bytes[$];

  logic [7:0]         window [0:WINDOW_DEPTH_DEF-1];
  logic [POS_W-1:0]   wr_pos;
  logic [7:0]         tok_flags;
  logic [2:0]         tok_idx;
  phase_t             phase;
  logic [7:0]         match_hi;
  logic [LIMIT_W-1:0] produced;
  logic [LIMIT_W-1:0] out_limit;
  bit                 halted;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < 50) begin
      $display("ERROR @%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    errors++;
  endtask

  function automatic void clear_stream();
    foreach (window[i]) window[i] = FILL_BYTE;
    wr_pos    = '0;
    tok_flags = '0;
    tok_idx   = '0;
    phase     = PH_FLAG;
    match_hi  = '0;
    produced  = '0;
    halted    = 1'b0;
  endfunction

  function automatic void next_token();
    tok_idx = tok_idx + 3'd1;
    phase   = (tok_idx == 3'd0) ? PH_FLAG : PH_TOKEN;
  endfunction

  // Produce one byte unless the stream has hit its output limit.
  function automatic bit put_byte(input logic [7:0] b);
    out_beat_t beat;
    if (halted || produced >= out_limit) begin
      halted = 1'b1;
      return 1'b0;
    end
    beat.data     = b;
    beat.run_last = 1'b0;
    expected_bytes.push_back(beat);
    window[wr_pos] = b;
    wr_pos   = wr_pos + 1'b1;
    produced = produced + 1'b1;
    if (produced >= out_limit) halted = 1'b1;
    return 1'b1;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic [CODE_W-1:0] code;
    int unsigned       len;
    int unsigned       j;
    int                base;
    bit                ok;
    out_beat_t         tail;
    base = expected_bytes.size();
    if (produced >= out_limit) halted = 1'b1;
    if (!halted) begin
      case (phase)
        PH_TOKEN: begin
          if (tok_flags[tok_idx]) begin
            match_hi = b;
            phase    = PH_LOW;
          end else begin
            void'(put_byte(b));
            next_token();
          end
        end
        PH_LOW: begin
          code = {match_hi, b};
          len  = code[LEN_W-1:0] + 2;
          j    = 0;
          ok   = 1'b1;
          // copy one byte at a time so overlapping copies see fresh bytes
          while (ok && j < len) begin
            ok = put_byte(window[POS_W'(code[CODE_W-1:LEN_W] + j)]);
            j++;
          end
          next_token();
        end
        default: begin
          tok_flags = b;
          tok_idx   = '0;
          phase     = PH_TOKEN;
        end
      endcase
    end
    if (expected_bytes.size() > base) begin
      tail = expected_bytes.pop_back();
      tail.run_last = 1'b1;
      expected_bytes.push_back(tail);
    end
    if (last) clear_stream();
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      out_limit = LIMIT_RESET;
      clear_stream();
      expected_bytes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("result transaction with nothing expected", int'(out_byte), 0);
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.data)
            report_mismatch("out_byte", int'(out_byte), int'(want.data));
          if (out_run_last !== want.run_last)
            report_mismatch("out_run_last", int'(out_run_last), int'(want.run_last));
        end
      end
      if (cfg_wr_en) out_limit = cfg_wr_data;
      if (in_valid && !in_stall) decode_byte(in_byte, in_last);
    end
    pending <= expected_bytes.size();
  end

endmodule

/* sim/tb_lzss_decompressor.sv */
// ----------------------------------------------------------------------------
// tb_lzss_decompressor
// Drives compressed streams into the decompressor under several output
// limits, with bursty input and a stalling receiver, and reports the verdict
// from the checker that runs beside the block.
// ----------------------------------------------------------------------------
module tb_lzss_decompressor;
  import lzd_pkg::*;

  localparam int DRAIN_CYCLES = 80;
  localparam int QUIET_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 250;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_item_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_byte;
  logic               in_last;
  logic               out_valid;
  logic               out_stall;
  logic [7:0]         out_byte;
  logic               out_run_last;
  logic               cfg_wr_en;
  logic [LIMIT_W-1:0] cfg_wr_data;
  int                 errors;
  int                 pending;
  int                 quiet_cycles;
  bit                 hold_req;

  in_item_t stim[$];

  lzss_decompressor dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_run_last (out_run_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  lzss_decompressor_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_run_last (out_run_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .errors       (errors),
    .pending      (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // End the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("lzss_decompressor verification failed");
      $finish;
    end
  end

  // Receiver: segments of free flow, random stalls and a fixed pattern,
  // plus one long hold-off on request.
  initial begin
    int mode;
    int seg;
    int cyc;
    bit hold_done;
    out_stall = 1'b0;
    cyc = 0;
    hold_done = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 2);
        seg  = $urandom_range(5, 60);
        repeat (seg) begin
          @(negedge clk);
          cyc++;
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 99) < 45);
            default: out_stall <= (cyc % 3 == 0);
          endcase
        end
      end
    end
  end

  function automatic void add(input logic [7:0] b, input logic last);
    in_item_t it;
    it.data = b;
    it.last = last;
    stim.push_back(it);
  endfunction

  // Mostly well-formed streams with random content; some noise and
  // truncated matches mixed in.
  task automatic build_random(input int n_items, input bit end_clean);
    logic [7:0]       flag;
    logic [POS_W-1:0] pos;
    logic [3:0]       lc;
    int               est;
    int               start;
    int               t;
    bit               ended;
    in_item_t         tail;
    start = stim.size();
    est = 0;
    while (stim.size() - start < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6))
          add(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        est = 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       flag = 8'h00;
          1:       flag = 8'hFF;
          default: flag = 8'($urandom_range(0, 255));
        endcase
        add(flag, 1'b0);
        t = 0;
        ended = 1'b0;
        while (t < 8 && !ended) begin
          if (flag[t]) begin
            case ($urandom_range(0, 3))
              0:       pos = POS_W'($urandom_range(0, 4095));
              1:       pos = POS_W'(est - 1);
              default: pos = POS_W'(est - $urandom_range(1, 24));
            endcase
            lc = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 39) == 0) begin
              // drop the low byte: the match never completes
              add(pos[11:4], 1'b1);
              ended = 1'b1;
            end else begin
              add(pos[11:4], 1'b0);
              add({pos[3:0], lc}, 1'b0);
              est += lc + 2;
            end
          end else begin
            add(8'($urandom_range(0, 255)), 1'b0);
            est++;
          end
          if (!ended && $urandom_range(0, 29) == 0) begin
            tail = stim.pop_back();
            tail.last = 1'b1;
            stim.push_back(tail);
            ended = 1'b1;
          end
          t++;
        end
        if (ended) est = 0;
      end
    end
    if (end_clean) begin
      tail = stim.pop_back();
      tail.last = 1'b1;
      stim.push_back(tail);
    end
  endtask

  task automatic drive_all();
    in_item_t it;
    int       burst;
    burst = 0;
    while (stim.size() > 0) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 16);
        if ($urandom_range(0, 2) != 0) begin
          @(negedge clk);
          in_valid <= 1'b0;
          repeat ($urandom_range(0, 5)) @(negedge clk);
        end
      end
      it = stim.pop_front();
      @(negedge clk);
      in_valid <= 1'b1;
      in_byte  <= it.data;
      in_last  <= it.last;
      do @(posedge clk); while (in_stall);
      burst--;
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait until every expected byte is out, then let trailing work finish.
  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [LIMIT_W-1:0] lim, input int n_items,
                           input bit end_clean, input bit hold);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lim;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    build_random(n_items, end_clean);
    if (hold) hold_req = 1'b1;
    drive_all();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_byte     = '0;
    in_last     = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    hold_req    = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Flag 0x56: lit, match, match, lit, match, lit, match, lit.
    add(8'h56, 1'b0);
    add(8'h00, 1'b0);
    add(8'h00, 1'b0); add(8'h0F, 1'b0);  // position 0, length 17: overlapping run
    add(8'hFF, 1'b0); add(8'hF0, 1'b0);  // position 0xFFF, length 2: wraps
    add(8'hFF, 1'b0);
    add(8'h00, 1'b0); add(8'h10, 1'b0);
    add(8'h41, 1'b0);
    add(8'h12, 1'b0); add(8'h33, 1'b0);  // untouched fill region
    add(8'h7E, 1'b0);
    // All matches; the second one loses its low byte at end of stream.
    add(8'hFF, 1'b0);
    add(8'h00, 1'b0); add(8'h05, 1'b0);
    add(8'hAB, 1'b1);
    // Fresh stream ends on a literal, then one that ends on its flag byte.
    add(8'h00, 1'b0);
    add(8'h55, 1'b1);
    add(8'h01, 1'b1);
    drive_all();

    // Limit phases; the second continues a stream under a lowered limit.
    run_phase(32'd40, 40, 1'b0, 1'b0);
    run_phase(32'd3, 15, 1'b1, 1'b0);
    run_phase(32'd0, 15, 1'b1, 1'b0);
    run_phase(32'd1, 15, 1'b1, 1'b0);
    run_phase(32'hFFFF_FFFE, 120, 1'b1, 1'b1);
    run_phase($urandom_range(10, 200), 40, 1'b0, 1'b0);
    run_phase(32'hFFFF_FFFF, 40, 1'b1, 1'b0);

    wait_drained();
    if (errors == 0 && pending == 0) begin
      $display("lzss_decompressor verification clean");
    end else begin
      $display("lzss_decompressor verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/lzd_pkg.sv
rtl/core/lzd_ram.sv
rtl/core/lzd_front.sv
rtl/core/lzd_queue.sv
rtl/core/lzd_back.sv
rtl/core/lzss_decompressor.sv
rtl/core/lzd_checker.sv
sim/lzss_decompressor_checker.sv
sim/tb_lzss_decompressor.sv
